>>> hw/rtl/rasr_pkg.sv
// Package: commands, datapath ops, controller states and control/status structs for the rational unit.
package rasr_pkg;

    typedef enum logic [1:0] {
        CMD_NORM = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_SUB  = 2'd2,
        CMD_EQ   = 2'd3
    } t_cmd;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,     // clear zero flag; operands are captured on accept
        OP_GCD_A,    // start gcd of left magnitudes
        OP_DIV_A,    // divide left pair by gcd
        OP_GCD_B,
        OP_DIV_B,
        OP_GCD_D,    // gcd of the two denominators
        OP_SCALE,    // divide denominators by g
        OP_MUL,      // shift-add products of both scaled numerators
        OP_COMBINE,  // add or subtract scaled numerators
        OP_DIVT,     // divide t by g, keep remainder
        OP_GCD_R,    // gcd of g and remainder
        OP_DIVT2,    // divide t by g2
        OP_DEN,      // divide b.den by g2, then form denominator product
        OP_FINISH    // form result
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_GA, ST_DA, ST_GB, ST_DB, ST_GD, ST_SC, ST_MUL, ST_CMB,
        ST_DT, ST_GR, ST_DT2, ST_DEN, ST_FIN, ST_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic start;   // pulse: begin operation
    } t_ctl;

    typedef struct packed {
        logic busy;    // iterative unit still working
        logic zero_t;  // combined numerator is zero
    } t_sts;

endpackage

>>> hw/rtl/rasr_if.sv
// Valid/ready channel interface with source and sink modports.
interface rasr_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/rational_add_sub_reduce_top.sv
// Rational add/subtract/compare unit: normalizes both operands, combines over the lcm of
// the denominators and reduces. One request at a time. All work runs on a one-bit-per-cycle
// divider (2*WIDTH+1 steps per divide) that also serves the gcd loops: each Euclid step of a
// gcd runs one divide. Add and subtract run up to four gcds, nine divides and three WIDTH-step
// shift-add products; normalize and compare skip the combine phase. The result register holds
// until taken.
module rational_add_sub_reduce_top #(
    parameter int WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rasr_if.sink   in_req,
    rasr_if.source out_rsp
);
    import rasr_pkg::*;

    // in_req.data = {command, left_num, left_den, right_num, right_den}
    // out_rsp.data = {result_num, result_den, is_equal, overflow}
    rasr_pkg::t_ctl w_ctl;
    rasr_pkg::t_sts w_sts;
    logic w_in_ready, w_out_valid, w_ld;
    logic [WIDTH-1:0] w_num;
    logic [WIDTH-2:0] w_den;
    logic w_eq, w_ovf;

    assign w_ld = in_req.valid && w_in_ready;
    assign in_req.ready  = w_in_ready;
    assign out_rsp.valid = w_out_valid;
    assign out_rsp.data  = {w_num, w_den, w_eq, w_ovf};

    rasr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_req.valid), .o_in_ready(w_in_ready),
        .i_cmd(in_req.data[4*WIDTH+1:4*WIDTH]),
        .o_out_valid(w_out_valid), .i_out_ready(out_rsp.ready),
        .o_ctl(w_ctl), .i_sts(w_sts)
    );

    rasr_dp #(.WIDTH(WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ld(w_ld),
        .i_cmd(in_req.data[4*WIDTH+1:4*WIDTH]),
        .i_ln(in_req.data[4*WIDTH-1:3*WIDTH]),
        .i_ld_den(in_req.data[3*WIDTH-1:2*WIDTH]),
        .i_rn(in_req.data[2*WIDTH-1:WIDTH]),
        .i_rd(in_req.data[WIDTH-1:0]),
        .i_ctl(w_ctl), .o_sts(w_sts),
        .o_num(w_num), .o_den(w_den), .o_eq(w_eq), .o_ovf(w_ovf)
    );

    // Never accept while a result is pending.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_valid |-> !w_in_ready) else $error("accept while result pending");
    // Overflow and equal are never both set.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_valid |-> !(w_eq && w_ovf)) else $error("equal and overflow both set");
    // Overflowed result is 0/1.
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && w_ovf) |-> (w_num == '0 && w_den == (WIDTH-1)'(1)))
        else $error("overflow result not 0/1");
endmodule

>>> hw/rtl/rasr_ctrl.sv
// Controller state machine sequencing the rational datapath.
module rasr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_cmd,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output rasr_pkg::t_ctl  o_ctl,
    input  rasr_pkg::t_sts  i_sts
);
    import rasr_pkg::*;

    t_state r_state, n_state;
    logic   r_started, n_started;
    logic [1:0] r_cmd, n_cmd;

    // Hold state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_started <= 1'b0;
            r_cmd     <= 2'd0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_cmd     <= n_cmd;
        end
    end

    // Advance through the operation sequence; each multi-cycle op starts once.
    always_comb begin
        logic adv;
        n_state   = r_state;
        n_started = r_started;
        n_cmd     = r_cmd;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_ctl.op    = OP_NONE;
        o_ctl.start = 1'b0;
        adv = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin o_ctl.op = OP_LOAD; o_ctl.start = 1'b1; n_state = ST_GA; end
            ST_GA:   begin o_ctl.op = OP_GCD_A; adv = 1'b1; end
            ST_DA:   begin o_ctl.op = OP_DIV_A; adv = 1'b1; end
            ST_GB:   begin o_ctl.op = OP_GCD_B; adv = 1'b1; end
            ST_DB:   begin o_ctl.op = OP_DIV_B; adv = 1'b1; end
            ST_GD:   begin o_ctl.op = OP_GCD_D; adv = 1'b1; end
            ST_SC:   begin o_ctl.op = OP_SCALE; adv = 1'b1; end
            ST_MUL:  begin o_ctl.op = OP_MUL; adv = 1'b1; end
            ST_CMB:  begin o_ctl.op = OP_COMBINE; o_ctl.start = 1'b1; n_state = ST_DT; end
            ST_DT:   begin o_ctl.op = OP_DIVT; adv = 1'b1; end
            ST_GR:   begin o_ctl.op = OP_GCD_R; adv = 1'b1; end
            ST_DT2:  begin o_ctl.op = OP_DIVT2; adv = 1'b1; end
            ST_DEN:  begin o_ctl.op = OP_DEN; adv = 1'b1; end
            ST_FIN:  begin o_ctl.op = OP_FINISH; o_ctl.start = 1'b1; n_state = ST_OUT; end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase

        // Multi-cycle ops: pulse start, then wait for not busy.
        if (adv) begin
            if (!r_started) begin
                o_ctl.start = 1'b1;
                n_started   = 1'b1;
            end else if (!i_sts.busy) begin
                n_started = 1'b0;
                unique case (r_state)
                    ST_DB: n_state = (r_cmd == CMD_NORM || r_cmd == CMD_EQ) ? ST_FIN : ST_GD;
                    ST_GA: n_state = ST_DA;
                    ST_DA: n_state = ST_GB;
                    ST_GB: n_state = ST_DB;
                    ST_GD: n_state = ST_SC;
                    ST_SC: n_state = ST_MUL;
                    ST_MUL: n_state = ST_CMB;
                    ST_DT: n_state = i_sts.zero_t ? ST_FIN : ST_GR;
                    ST_GR: n_state = ST_DT2;
                    ST_DT2: n_state = ST_DEN;
                    ST_DEN: n_state = ST_FIN;
                    default: n_state = ST_FIN;
                endcase
            end
        end
    end
endmodule

>>> hw/rtl/rasr_dp.sv
// Datapath: operand registers, shared gcd/divide/multiply units, result forming.
module rasr_dp #(
    parameter int WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ld,
    input  logic [1:0]            i_cmd,
    input  logic [WIDTH-1:0]      i_ln,
    input  logic [WIDTH-1:0]      i_ld_den,
    input  logic [WIDTH-1:0]      i_rn,
    input  logic [WIDTH-1:0]      i_rd,
    input  rasr_pkg::t_ctl        i_ctl,
    output rasr_pkg::t_sts        o_sts,
    output logic [WIDTH-1:0]      o_num,
    output logic [WIDTH-2:0]      o_den,
    output logic                  o_eq,
    output logic                  o_ovf
);
    import rasr_pkg::*;

    localparam int W  = WIDTH;      // magnitude width (holds 2^(W-1))
    localparam int TW = 2 * W + 1;  // combined numerator width
    localparam int CW = $clog2(TW + 1);

    logic [1:0]    r_cmd;
    logic          r_an, r_bn;             // signs
    logic [W-1:0]  r_anum, r_aden, r_bnum, r_bden;
    logic          r_ln, r_ld, r_rn, r_rd; // raw sign bits
    logic [W-1:0]  r_g, r_g2, r_rem;
    logic [W-1:0]  r_da, r_db;             // a.den/g, b.den/g
    // gcd unit
    logic [W-1:0]  r_ga, r_gb;
    logic          r_gbusy, r_gmod;
    // divider (TW-bit dividend, W-bit divisor)
    logic [TW-1:0] r_dq;
    logic [W:0]    r_dr;
    logic [W-1:0]  r_dd;
    logic [CW-1:0] r_dcnt;
    logic          r_dbusy;
    // multiplier (two shift-add products)
    logic [2*W-1:0] r_p, r_q, r_m1a, r_m2a;
    logic [W-1:0]   r_m1b, r_m2b;
    logic [CW-1:0]  r_mcnt;
    logic           r_mbusy;
    logic [TW-1:0]  r_t, r_num;
    logic [2*W-1:0] r_den;
    logic           r_neg;
    logic           r_zero;
    logic [WIDTH-1:0] r_onum;
    logic [WIDTH-2:0] r_oden;
    logic           r_oeq, r_oovf;
    // Sequencing sub-phases inside one controller op.
    logic [1:0]     r_sub;

    // Magnitude of a W-bit two's complement word.
    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // Divider step (restoring).
    logic [W:0]   w_rs;
    logic [W+1:0] w_diff;
    assign w_rs   = {r_dr[W-1:0], r_dq[TW-1]};
    assign w_diff = {1'b0, w_rs} - {2'b00, r_dd};

    // Divider input selection per operation.
    logic [TW-1:0] w_divn;
    logic [W-1:0]  w_divd;
    always_comb begin
        w_divn = '0;
        w_divd = r_g;
        unique case (i_ctl.op)
            OP_DIVT, OP_DIVT2: begin
                w_divn = r_t;
                w_divd = (i_ctl.op == OP_DIVT2) ? r_g2 : r_g;
            end
            OP_SCALE: begin w_divn = TW'(r_aden); w_divd = r_g; end
            OP_DEN:   begin w_divn = TW'(r_bden); w_divd = r_g2; end
            default:  begin w_divn = '0; w_divd = r_g; end
        endcase
    end

    // Hold busy until the bookkeeping after the last divide of an op is done.
    logic w_post;
    always_comb begin
        unique case (i_ctl.op)
            OP_DIV_A, OP_DIV_B, OP_SCALE: w_post = (r_sub != 2'd2);
            OP_DIVT, OP_DIVT2, OP_DEN:    w_post = (r_sub == 2'd0);
            default:                      w_post = 1'b0;
        endcase
    end

    logic w_dbusy;
    assign w_dbusy = r_dbusy || r_gbusy || r_mbusy || r_gmod || w_post;
    assign o_sts.busy   = w_dbusy;
    assign o_sts.zero_t = (r_t == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gbusy <= 1'b0;
            r_gmod  <= 1'b0;
            r_dbusy <= 1'b0;
            r_mbusy <= 1'b0;
            r_sub   <= 2'd0;
            r_zero  <= 1'b0;
            r_onum  <= '0;
            r_oden  <= (W-1)'(1);
            r_oeq   <= 1'b0;
            r_oovf  <= 1'b0;
        end else begin
            // Normalize zero operands to 0/1 up front so later steps see clean values.
            if (i_ld) begin
                r_cmd <= i_cmd;
                r_ln  <= i_ln[W-1];
                r_ld  <= i_ld_den[W-1];
                r_rn  <= i_rn[W-1];
                r_rd  <= i_rd[W-1];
                r_anum <= (i_ln == '0 || i_ld_den == '0) ? '0 : mag(i_ln);
                r_aden <= (i_ln == '0 || i_ld_den == '0) ? W'(1) : mag(i_ld_den);
                r_bnum <= (i_rn == '0 || i_rd == '0) ? '0 : mag(i_rn);
                r_bden <= (i_rn == '0 || i_rd == '0) ? W'(1) : mag(i_rd);
            end

            // gcd: iterate a,b <- b, a mod b; mod done by divider.
            if (i_ctl.start && (i_ctl.op == OP_GCD_A || i_ctl.op == OP_GCD_B ||
                                i_ctl.op == OP_GCD_D || i_ctl.op == OP_GCD_R)) begin
                unique case (i_ctl.op)
                    OP_GCD_A: begin r_ga <= r_anum; r_gb <= r_aden; end
                    OP_GCD_B: begin r_ga <= r_bnum; r_gb <= r_bden; end
                    OP_GCD_D: begin r_ga <= r_aden; r_gb <= r_bden; end
                    default:  begin r_ga <= r_g;    r_gb <= r_rem;  end
                endcase
                r_gbusy <= 1'b1;
                r_gmod  <= 1'b0;
            end else if (r_gbusy && !r_gmod) begin
                if (r_gb == '0) begin
                    r_gbusy <= 1'b0;
                    if (i_ctl.op == OP_GCD_R) r_g2 <= r_ga;
                    else r_g <= r_ga;
                end else begin
                    r_gmod  <= 1'b1;
                    r_dq    <= TW'(r_ga);
                    r_dr    <= '0;
                    r_dd    <= r_gb;
                    r_dcnt  <= CW'(TW);
                    r_dbusy <= 1'b1;
                end
            end else if (r_gmod && !r_dbusy) begin
                r_ga   <= r_gb;
                r_gb   <= r_dr[W-1:0];
                r_gmod <= 1'b0;
            end

            // Division start for plain divide ops.
            if (i_ctl.start && (i_ctl.op == OP_DIV_A || i_ctl.op == OP_DIV_B ||
                                i_ctl.op == OP_DIVT || i_ctl.op == OP_DIVT2 ||
                                i_ctl.op == OP_SCALE || i_ctl.op == OP_DEN)) begin
                r_sub   <= 2'd0;
                r_dr    <= '0;
                r_dd    <= w_divd;
                r_dcnt  <= CW'(TW);
                r_dbusy <= 1'b1;
                unique case (i_ctl.op)
                    OP_DIV_A: r_dq <= TW'(r_anum);
                    OP_DIV_B: r_dq <= TW'(r_bnum);
                    default:  r_dq <= w_divn;
                endcase
            end else if (r_dbusy) begin
                // one quotient bit per cycle
                r_dq <= {r_dq[TW-2:0], ~w_diff[W+1]};
                r_dr <= w_diff[W+1] ? w_rs : w_diff[W:0];
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == CW'(1)) r_dbusy <= 1'b0;
            end else if (!r_gbusy && !r_mbusy) begin
                // Post-division bookkeeping: two-part ops chain a second divide.
                priority case (i_ctl.op)
                    OP_DIV_A: begin
                        if (r_sub == 2'd0) begin
                            r_anum <= r_dq[W-1:0];
                            r_sub  <= 2'd1;
                            r_dq   <= TW'(r_aden);
                            r_dr   <= '0;
                            r_dcnt <= CW'(TW);
                            r_dbusy <= 1'b1;
                        end else if (r_sub == 2'd1) begin
                            r_aden <= r_dq[W-1:0];
                            r_sub  <= 2'd2;
                        end
                    end
                    OP_DIV_B: begin
                        if (r_sub == 2'd0) begin
                            r_bnum <= r_dq[W-1:0];
                            r_sub  <= 2'd1;
                            r_dq   <= TW'(r_bden);
                            r_dr   <= '0;
                            r_dcnt <= CW'(TW);
                            r_dbusy <= 1'b1;
                        end else if (r_sub == 2'd1) begin
                            r_bden <= r_dq[W-1:0];
                            r_sub  <= 2'd2;
                        end
                    end
                    OP_SCALE: begin
                        if (r_sub == 2'd0) begin
                            r_da   <= r_dq[W-1:0];
                            r_sub  <= 2'd1;
                            r_dq   <= TW'(r_bden);
                            r_dr   <= '0;
                            r_dcnt <= CW'(TW);
                            r_dbusy <= 1'b1;
                        end else if (r_sub == 2'd1) begin
                            r_db  <= r_dq[W-1:0];
                            r_sub <= 2'd2;
                        end
                    end
                    OP_DIVT: if (r_sub == 2'd0) begin r_rem <= r_dr[W-1:0]; r_sub <= 2'd1; end
                    OP_DIVT2: if (r_sub == 2'd0) begin r_num <= r_dq; r_sub <= 2'd1; end
                    OP_DEN: if (r_sub == 2'd0) begin
                        r_sub <= 2'd1;
                        r_m1a <= (2*W)'(r_da);
                        r_m1b <= r_dq[W-1:0];
                        r_den <= '0;
                        r_mcnt <= CW'(W);
                        r_mbusy <= 1'b1;
                    end
                    default: ;
                endcase
            end

            // Shift-add multipliers: p = anum*db, q = bnum*da (or den = da*(b.den/g2)).
            if (i_ctl.start && i_ctl.op == OP_MUL) begin
                r_m1a <= (2*W)'(r_anum); r_m1b <= r_db;
                r_m2a <= (2*W)'(r_bnum); r_m2b <= r_da;
                r_p <= '0; r_q <= '0;
                r_mcnt <= CW'(W);
                r_mbusy <= 1'b1;
            end else if (r_mbusy) begin
                if (i_ctl.op == OP_DEN) begin
                    if (r_m1b[0]) r_den <= r_den + r_m1a;
                end else begin
                    if (r_m1b[0]) r_p <= r_p + r_m1a;
                    if (r_m2b[0]) r_q <= r_q + r_m2a;
                end
                r_m1a <= r_m1a << 1; r_m1b <= r_m1b >> 1;
                r_m2a <= r_m2a << 1; r_m2b <= r_m2b >> 1;
                r_mcnt <= r_mcnt - 1'b1;
                if (r_mcnt == CW'(1)) r_mbusy <= 1'b0;
            end

            // Combine signed terms.
            if (i_ctl.start && i_ctl.op == OP_COMBINE) begin
                logic bneg;
                bneg = ((r_bnum != '0) && (r_rn != r_rd)) ^
                       ((r_cmd == CMD_SUB) && (r_bnum != '0));
                if ((r_anum != '0 && (r_ln != r_ld)) == bneg) begin
                    r_t   <= TW'(r_p) + TW'(r_q);
                    r_neg <= (r_anum != '0) && (r_ln != r_ld);
                end else if (r_p >= r_q) begin
                    r_t   <= TW'(r_p - r_q);
                    r_neg <= (r_anum != '0) && (r_ln != r_ld);
                end else begin
                    r_t   <= TW'(r_q - r_p);
                    r_neg <= bneg;
                end
            end

            // Form result.
            if (i_ctl.start && i_ctl.op == OP_FINISH) begin
                logic          neg;
                logic [TW-1:0] n;
                logic [2*W-1:0] d;
                logic          an, bn;
                an = (r_anum != '0) && (r_aden != '0) && (r_ln != r_ld);
                bn = (r_bnum != '0) && (r_bden != '0) && (r_rn != r_rd);
                r_oeq  <= 1'b0;
                r_oovf <= 1'b0;
                r_onum <= '0;
                r_oden <= (W-1)'(1);
                if (r_cmd == CMD_EQ) begin
                    r_oeq <= (an == bn) &&
                             (((r_anum == '0 || r_aden == '0) &&
                               (r_bnum == '0 || r_bden == '0)) ||
                              (r_anum != '0 && r_aden != '0 && r_bnum != '0 &&
                               r_bden != '0 && r_anum == r_bnum && r_aden == r_bden));
                end else begin
                    if (r_cmd == CMD_NORM) begin
                        neg = an;
                        n   = (r_anum == '0 || r_aden == '0) ? '0 : TW'(r_anum);
                        d   = (2*W)'(r_aden);
                    end else begin
                        neg = r_neg;
                        n   = r_zero ? '0 : r_num;
                        d   = r_den;
                    end
                    if (n != '0) begin
                        if (n > (neg ? TW'({1'b1, {(W-1){1'b0}}}) : TW'({(W-1){1'b1}})) ||
                            d > (2*W)'({(W-1){1'b1}})) begin
                            r_oovf <= 1'b1;
                        end else begin
                            r_onum <= neg ? (~n[W-1:0] + 1'b1) : n[W-1:0];
                            r_oden <= d[W-2:0];
                        end
                    end
                end
            end

            if (i_ctl.start && i_ctl.op == OP_LOAD) r_zero <= 1'b0;
            if (i_ctl.start && i_ctl.op == OP_DIVT) r_zero <= (r_t == '0);
        end
    end

    assign o_num = r_onum;
    assign o_den = r_oden;
    assign o_eq  = r_oeq;
    assign o_ovf = r_oovf;
endmodule
